// ----- rtl/mmse_fde_qpsk_demap_defines.svh -----
// Assertion helpers for the MMSE equalizer / QPSK demapper.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef MMSE_FDE_QPSK_DEMAP_DEFINES_SVH
`define MMSE_FDE_QPSK_DEMAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFQD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFQD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mfqd_pkg.sv -----
package mfqd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int WEIGHT_W         = 16;
   localparam int NOISE_W          = 16;
   localparam int NOISE_SHIFT      = 14;
   localparam int WEIGHT_SHIFT     = 22;
   localparam int EQ_SHIFT         = 10;
   // quotient of 2*num/den, two bits above the weight so rounding and clipping see it
   localparam int QUOT_W           = WEIGHT_W + 2;

   typedef struct packed {
      logic den_zero;
      logic neg_re;
      logic neg_im;
   } flag_type;

   function automatic int den_width(input int sw);
      return ((2 * sw > NOISE_W + NOISE_SHIFT) ? 2 * sw : NOISE_W + NOISE_SHIFT) + 1;
   endfunction

endpackage

// ----- rtl/mmse_fde_qpsk_demap.sv -----
// MMSE frequency-domain equalizer with QPSK demap, one subcarrier per beat.
// Each request beat carries the received sample and channel estimate (Q2.13);
// each response beat carries the weight 0.5*conj(H)/(|H|^2 + 2*noise) clipped to
// Q5.10, the equalized sample clipped to Q2.13, the two QPSK bits and symbol_ok
// (in tuser), which is low for a zero equalized sample or zero denominator.
// Takes one beat per clock while the output skid buffer is empty (rsp backpressure stalls it).
// Most of the depth is in the weight divider, two lanes of 18 restoring stages,
// one quotient bit per stage. The user must write noise_variance through the csr
// port only while no beat is in flight; the block itself does not enforce this.
`include "mmse_fde_qpsk_demap_defines.svh"

module mmse_fde_qpsk_demap import mfqd_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int REQ_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((2 * WEIGHT_W + 2 * SAMPLE_WIDTH + 2 + 7) / 8) * 8,
   localparam int PAY_W = 2 * WEIGHT_W + 2 * SAMPLE_WIDTH + 3,
   localparam int DEN_W = den_width(SAMPLE_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // rx_re, rx_im, chan_re, chan_im
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // weight_re, weight_im, eq_re, eq_im,
                                           // bit_first, bit_second
   output logic               rsp_tuser,   // symbol_ok
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [NOISE_W-1:0] csr_data     // noise_variance
);

   logic                           adv;
   logic [NOISE_W-1:0]             noise_ff;

   logic                           d_valid;
   logic signed [SAMPLE_WIDTH-1:0] d_rx_re, d_rx_im;
   logic        [SAMPLE_WIDTH-1:0] d_mag_re, d_mag_im;
   logic        [DEN_W-1:0]        d_den;
   flag_type                       d_flags;

   logic                           q_valid;
   logic signed [SAMPLE_WIDTH-1:0] q_rx_re, q_rx_im;
   logic        [QUOT_W-1:0]       q_re, q_im;
   flag_type                       q_flags;

   logic                           e_valid;
   logic signed [WEIGHT_W-1:0]     weight_re, weight_im;
   logic signed [SAMPLE_WIDTH-1:0] eq_re, eq_im;
   logic                           bit_first, bit_second, symbol_ok;

   logic [PAY_W-1:0]               pay_in;
   logic [PAY_W-1:0]               pay_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= '0;
      end else if (csr_valid) begin
         noise_ff <= csr_data;
      end
   end

   assign req_tready = adv;

   mfqd_den #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_den (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_tvalid),
      .rx_re      ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .rx_im      ($signed(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
      .chan_re    ($signed(req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH])),
      .chan_im    ($signed(req_tdata[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH])),
      .noise      (noise_ff),
      .out_valid  (d_valid),
      .out_rx_re  (d_rx_re),
      .out_rx_im  (d_rx_im),
      .out_mag_re (d_mag_re),
      .out_mag_im (d_mag_im),
      .out_den    (d_den),
      .out_flags  (d_flags)
   );

   mfqd_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (d_valid),
      .rx_re       (d_rx_re),
      .rx_im       (d_rx_im),
      .mag_re      (d_mag_re),
      .mag_im      (d_mag_im),
      .den         (d_den),
      .flags       (d_flags),
      .out_valid   (q_valid),
      .out_rx_re   (q_rx_re),
      .out_rx_im   (q_rx_im),
      .out_quot_re (q_re),
      .out_quot_im (q_im),
      .out_flags   (q_flags)
   );

   mfqd_eq #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_eq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (q_valid),
      .rx_re      (q_rx_re),
      .rx_im      (q_rx_im),
      .quot_re    (q_re),
      .quot_im    (q_im),
      .flags      (q_flags),
      .out_valid  (e_valid),
      .weight_re  (weight_re),
      .weight_im  (weight_im),
      .eq_re      (eq_re),
      .eq_im      (eq_im),
      .bit_first  (bit_first),
      .bit_second (bit_second),
      .symbol_ok  (symbol_ok)
   );

   assign pay_in = {symbol_ok, bit_second, bit_first, eq_im, eq_re, weight_im, weight_re};

   mfqd_skid #(.DATA_W(PAY_W)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid),
      .in_ready  (adv),
      .in_data   (pay_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (pay_out)
   );

   assign rsp_tdata = RSP_W'(pay_out[PAY_W-2:0]);
   assign rsp_tuser = pay_out[PAY_W-1];

   `MFQD_ASSERT_NOW(a_ok_nonzero, symbol_ok, (eq_re != '0) || (eq_im != '0), "symbol_ok with zero sample")
   `MFQD_ASSERT_NOW(a_bits_gated, !symbol_ok, !bit_first && !bit_second, "QPSK bits set on bad symbol")
   `MFQD_ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid, "input stalled with empty output")
   `MFQD_ASSERT_NEXT(a_stall_hold, !req_tready && !rsp_tready, !req_tready, "skid beat dropped")

endmodule

// ----- rtl/mfqd_den.sv -----
module mfqd_den import mfqd_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int DEN_W = den_width(SAMPLE_WIDTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_re,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_im,
   input  logic signed [SAMPLE_WIDTH-1:0] chan_re,
   input  logic signed [SAMPLE_WIDTH-1:0] chan_im,
   input  logic        [NOISE_W-1:0]      noise,
   output logic                           out_valid,
   output logic signed [SAMPLE_WIDTH-1:0] out_rx_re,
   output logic signed [SAMPLE_WIDTH-1:0] out_rx_im,
   output logic        [SAMPLE_WIDTH-1:0] out_mag_re,
   output logic        [SAMPLE_WIDTH-1:0] out_mag_im,
   output logic        [DEN_W-1:0]        out_den,
   output flag_type                       out_flags
);

   logic signed [2*SAMPLE_WIDTH-1:0] sq_re_full;
   logic signed [2*SAMPLE_WIDTH-1:0] sq_im_full;
   logic        [SAMPLE_WIDTH-1:0]   mag_re_in;
   logic        [SAMPLE_WIDTH-1:0]   mag_im_in;
   logic                             neg_im_in;

   logic                             v1_ff;
   logic        [2*SAMPLE_WIDTH-2:0] sq_re_ff;
   logic        [2*SAMPLE_WIDTH-2:0] sq_im_ff;
   logic        [SAMPLE_WIDTH-1:0]   mag_re_ff;
   logic        [SAMPLE_WIDTH-1:0]   mag_im_ff;
   logic                             neg_re_ff;
   logic                             neg_im_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rx_re1_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rx_im1_ff;

   logic        [DEN_W-1:0]          den_in;

   logic                             v2_ff;
   logic        [DEN_W-1:0]          den_ff;
   logic        [SAMPLE_WIDTH-1:0]   mag_re2_ff;
   logic        [SAMPLE_WIDTH-1:0]   mag_im2_ff;
   flag_type                         flags_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rx_re2_ff;
   logic signed [SAMPLE_WIDTH-1:0]   rx_im2_ff;

   assign sq_re_full = chan_re * chan_re;
   assign sq_im_full = chan_im * chan_im;
   assign mag_re_in  = chan_re[SAMPLE_WIDTH-1] ? ($unsigned(~chan_re) + SAMPLE_WIDTH'(1))
                                               : $unsigned(chan_re);
   assign mag_im_in  = chan_im[SAMPLE_WIDTH-1] ? ($unsigned(~chan_im) + SAMPLE_WIDTH'(1))
                                               : $unsigned(chan_im);
   // weight uses -chan_im, so its sign is set when chan_im is strictly positive
   assign neg_im_in  = !chan_im[SAMPLE_WIDTH-1] && (chan_im != '0);

   assign den_in = DEN_W'(sq_re_ff) + DEN_W'(sq_im_ff) + (DEN_W'(noise) << NOISE_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_re_ff   <= sq_re_full[2*SAMPLE_WIDTH-2:0];
         sq_im_ff   <= sq_im_full[2*SAMPLE_WIDTH-2:0];
         mag_re_ff  <= mag_re_in;
         mag_im_ff  <= mag_im_in;
         neg_re_ff  <= chan_re[SAMPLE_WIDTH-1];
         neg_im_ff  <= neg_im_in;
         rx_re1_ff  <= rx_re;
         rx_im1_ff  <= rx_im;

         den_ff            <= den_in;
         flags_ff.den_zero <= (den_in == '0);
         flags_ff.neg_re   <= neg_re_ff;
         flags_ff.neg_im   <= neg_im_ff;
         mag_re2_ff        <= mag_re_ff;
         mag_im2_ff        <= mag_im_ff;
         rx_re2_ff         <= rx_re1_ff;
         rx_im2_ff         <= rx_im1_ff;
      end
   end

   assign out_valid  = v2_ff;
   assign out_rx_re  = rx_re2_ff;
   assign out_rx_im  = rx_im2_ff;
   assign out_mag_re = mag_re2_ff;
   assign out_mag_im = mag_im2_ff;
   assign out_den    = den_ff;
   assign out_flags  = flags_ff;

endmodule

// ----- rtl/mfqd_div.sv -----
module mfqd_div import mfqd_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int DEN_W = den_width(SAMPLE_WIDTH),
   localparam int REM_W = SAMPLE_WIDTH + WEIGHT_SHIFT + 1,
   localparam int CMP_W = (REM_W > DEN_W + QUOT_W - 1) ? REM_W : DEN_W + QUOT_W - 1,
   localparam int NSTG  = QUOT_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_re,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_im,
   input  logic        [SAMPLE_WIDTH-1:0] mag_re,
   input  logic        [SAMPLE_WIDTH-1:0] mag_im,
   input  logic        [DEN_W-1:0]        den,
   input  flag_type                       flags,
   output logic                           out_valid,
   output logic signed [SAMPLE_WIDTH-1:0] out_rx_re,
   output logic signed [SAMPLE_WIDTH-1:0] out_rx_im,
   output logic        [QUOT_W-1:0]       out_quot_re,
   output logic        [QUOT_W-1:0]       out_quot_im,
   output flag_type                       out_flags
);

   // One restoring step per stage, both lanes side by side; stage s settles
   // quotient bit QUOT_W-1-s of floor(2*|h|*2^22 / den).
   logic                           vld_src [NSTG];
   logic        [REM_W-1:0]        rem_src [NSTG][2];
   logic        [QUOT_W-1:0]       quo_src [NSTG][2];
   logic        [DEN_W-1:0]        den_src [NSTG];
   flag_type                       flg_src [NSTG];
   logic signed [SAMPLE_WIDTH-1:0] rxr_src [NSTG];
   logic signed [SAMPLE_WIDTH-1:0] rxi_src [NSTG];

   logic        [REM_W-1:0]        rem_in  [NSTG][2];
   logic        [QUOT_W-1:0]       quo_in  [NSTG][2];

   logic                           vld_ff  [NSTG];
   logic        [REM_W-1:0]        rem_ff  [NSTG][2];
   logic        [QUOT_W-1:0]       quo_ff  [NSTG][2];
   logic        [DEN_W-1:0]        den_ff  [NSTG];
   flag_type                       flg_ff  [NSTG];
   logic signed [SAMPLE_WIDTH-1:0] rxr_ff  [NSTG];
   logic signed [SAMPLE_WIDTH-1:0] rxi_ff  [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_src
      if (s == 0) begin : g_head
         assign vld_src[0]    = in_valid;
         assign rem_src[0][0] = REM_W'(mag_re) << (WEIGHT_SHIFT + 1);
         assign rem_src[0][1] = REM_W'(mag_im) << (WEIGHT_SHIFT + 1);
         assign quo_src[0][0] = '0;
         assign quo_src[0][1] = '0;
         assign den_src[0]    = den;
         assign flg_src[0]    = flags;
         assign rxr_src[0]    = rx_re;
         assign rxi_src[0]    = rx_im;
      end else begin : g_body
         assign vld_src[s]    = vld_ff[s-1];
         assign rem_src[s][0] = rem_ff[s-1][0];
         assign rem_src[s][1] = rem_ff[s-1][1];
         assign quo_src[s][0] = quo_ff[s-1][0];
         assign quo_src[s][1] = quo_ff[s-1][1];
         assign den_src[s]    = den_ff[s-1];
         assign flg_src[s]    = flg_ff[s-1];
         assign rxr_src[s]    = rxr_ff[s-1];
         assign rxi_src[s]    = rxi_ff[s-1];
      end
   end

   always_comb begin
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rem_c;
      logic             ge;
      for (int s = 0; s < NSTG; s++) begin
         for (int l = 0; l < 2; l++) begin
            dsh          = CMP_W'(den_src[s]) << (QUOT_W - 1 - s);
            rem_c        = CMP_W'(rem_src[s][l]);
            ge           = (rem_c >= dsh);
            rem_in[s][l] = ge ? REM_W'(rem_c - dsh) : rem_src[s][l];
            quo_in[s][l] = quo_src[s][l] | (QUOT_W'(ge) << (QUOT_W - 1 - s));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NSTG; s++) vld_ff[s] <= vld_src[s];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NSTG; s++) begin
            rem_ff[s][0] <= rem_in[s][0];
            rem_ff[s][1] <= rem_in[s][1];
            quo_ff[s][0] <= quo_in[s][0];
            quo_ff[s][1] <= quo_in[s][1];
            den_ff[s]    <= den_src[s];
            flg_ff[s]    <= flg_src[s];
            rxr_ff[s]    <= rxr_src[s];
            rxi_ff[s]    <= rxi_src[s];
         end
      end
   end

   assign out_valid   = vld_ff[NSTG-1];
   assign out_rx_re   = rxr_ff[NSTG-1];
   assign out_rx_im   = rxi_ff[NSTG-1];
   assign out_quot_re = quo_ff[NSTG-1][0];
   assign out_quot_im = quo_ff[NSTG-1][1];
   assign out_flags   = flg_ff[NSTG-1];

endmodule

// ----- rtl/mfqd_eq.sv -----
module mfqd_eq import mfqd_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int PROD_W = SAMPLE_WIDTH + WEIGHT_W,
   localparam int SUM_W  = PROD_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_re,
   input  logic signed [SAMPLE_WIDTH-1:0] rx_im,
   input  logic        [QUOT_W-1:0]       quot_re,
   input  logic        [QUOT_W-1:0]       quot_im,
   input  flag_type                       flags,
   output logic                           out_valid,
   output logic signed [WEIGHT_W-1:0]     weight_re,
   output logic signed [WEIGHT_W-1:0]     weight_im,
   output logic signed [SAMPLE_WIDTH-1:0] eq_re,
   output logic signed [SAMPLE_WIDTH-1:0] eq_im,
   output logic                           bit_first,
   output logic                           bit_second,
   output logic                           symbol_ok
);

   localparam logic [QUOT_W-1:0] W_POS_MAX = QUOT_W'((1 << (WEIGHT_W - 1)) - 1);
   localparam logic [QUOT_W-1:0] W_NEG_MAX = QUOT_W'(1 << (WEIGHT_W - 1));
   localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] EQ_MAX  = SUM_W'({(SAMPLE_WIDTH-1){1'b1}});
   localparam logic signed [SUM_W-1:0] EQ_MIN  = -EQ_MAX - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] EQ_HALF = SUM_W'(1 << (EQ_SHIFT - 1));

   // t = floor(2*num/den); (t+1)>>1 is num/den rounded half away from zero
   function automatic logic signed [WEIGHT_W-1:0] clip_weight(
      input logic [QUOT_W-1:0] t,
      input logic              neg
   );
      logic [QUOT_W:0]   t1;
      logic [QUOT_W-1:0] rnd;
      t1  = {1'b0, t} + (QUOT_W+1)'(1);
      rnd = t1[QUOT_W:1];
      if (!neg) begin
         return (rnd > W_POS_MAX) ? W_MAX : $signed(rnd[WEIGHT_W-1:0]);
      end
      return (rnd > W_NEG_MAX) ? W_MIN : -$signed(rnd[WEIGHT_W-1:0]);
   endfunction

   // stage 1: weights
   logic signed [WEIGHT_W-1:0]     w_re_in, w_im_in;
   logic                           v1_ff;
   logic signed [WEIGHT_W-1:0]     w_re1_ff, w_im1_ff;
   logic signed [SAMPLE_WIDTH-1:0] rx_re1_ff, rx_im1_ff;

   // stage 2: partial products
   logic                           v2_ff;
   logic signed [PROD_W-1:0]       p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [WEIGHT_W-1:0]     w_re2_ff, w_im2_ff;

   // stage 3: complex sums
   logic                           v3_ff;
   logic signed [SUM_W-1:0]        s_re_ff, s_im_ff;
   logic signed [WEIGHT_W-1:0]     w_re3_ff, w_im3_ff;

   // stage 4: rescale and clip
   logic signed [SUM_W-1:0]        r_re_in, r_im_in;
   logic signed [SAMPLE_WIDTH-1:0] e_re_in, e_im_in;
   logic                           v4_ff;
   logic signed [SAMPLE_WIDTH-1:0] e_re4_ff, e_im4_ff;
   logic signed [WEIGHT_W-1:0]     w_re4_ff, w_im4_ff;

   // stage 5: demap
   logic                           ok_in;
   logic                           v5_ff;
   logic signed [SAMPLE_WIDTH-1:0] e_re5_ff, e_im5_ff;
   logic signed [WEIGHT_W-1:0]     w_re5_ff, w_im5_ff;
   logic                           b1_ff, b2_ff, ok_ff;

   assign w_re_in = flags.den_zero ? '0 : clip_weight(quot_re, flags.neg_re);
   assign w_im_in = flags.den_zero ? '0 : clip_weight(quot_im, flags.neg_im);

   // bias by half an LSB toward the sign, then floor: ties round away from zero
   assign r_re_in = (s_re_ff + (s_re_ff[SUM_W-1] ? EQ_HALF - SUM_W'(1) : EQ_HALF)) >>> EQ_SHIFT;
   assign r_im_in = (s_im_ff + (s_im_ff[SUM_W-1] ? EQ_HALF - SUM_W'(1) : EQ_HALF)) >>> EQ_SHIFT;

   always_comb begin
      if (r_re_in > EQ_MAX)      e_re_in = EQ_MAX[SAMPLE_WIDTH-1:0];
      else if (r_re_in < EQ_MIN) e_re_in = EQ_MIN[SAMPLE_WIDTH-1:0];
      else                       e_re_in = r_re_in[SAMPLE_WIDTH-1:0];
      if (r_im_in > EQ_MAX)      e_im_in = EQ_MAX[SAMPLE_WIDTH-1:0];
      else if (r_im_in < EQ_MIN) e_im_in = EQ_MIN[SAMPLE_WIDTH-1:0];
      else                       e_im_in = r_im_in[SAMPLE_WIDTH-1:0];
   end

   assign ok_in = (e_re4_ff != '0) || (e_im4_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_re1_ff  <= w_re_in;
         w_im1_ff  <= w_im_in;
         rx_re1_ff <= rx_re;
         rx_im1_ff <= rx_im;

         p_rr_ff  <= rx_re1_ff * w_re1_ff;
         p_ii_ff  <= rx_im1_ff * w_im1_ff;
         p_ri_ff  <= rx_re1_ff * w_im1_ff;
         p_ir_ff  <= rx_im1_ff * w_re1_ff;
         w_re2_ff <= w_re1_ff;
         w_im2_ff <= w_im1_ff;

         s_re_ff  <= SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
         s_im_ff  <= SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         w_re3_ff <= w_re2_ff;
         w_im3_ff <= w_im2_ff;

         e_re4_ff <= e_re_in;
         e_im4_ff <= e_im_in;
         w_re4_ff <= w_re3_ff;
         w_im4_ff <= w_im3_ff;

         e_re5_ff <= e_re4_ff;
         e_im5_ff <= e_im4_ff;
         w_re5_ff <= w_re4_ff;
         w_im5_ff <= w_im4_ff;
         ok_ff    <= ok_in;
         b1_ff    <= ok_in && (e_im4_ff < 0 || (e_im4_ff == '0 && e_re4_ff < 0));
         b2_ff    <= ok_in && (e_re4_ff < 0 || (e_re4_ff == '0 && e_im4_ff > 0));
      end
   end

   assign out_valid  = v5_ff;
   assign weight_re  = w_re5_ff;
   assign weight_im  = w_im5_ff;
   assign eq_re      = e_re5_ff;
   assign eq_im      = e_im5_ff;
   assign bit_first  = b1_ff;
   assign bit_second = b2_ff;
   assign symbol_ok  = ok_ff;

endmodule

// ----- rtl/mfqd_skid.sv -----
module mfqd_skid #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic              out_v_ff;
   logic              skid_v_ff;
   logic [DATA_W-1:0] out_d_ff;
   logic [DATA_W-1:0] skid_d_ff;
   logic              in_fire;

   // ready comes straight from a flop: the upstream pipeline never sees out_ready
   assign in_ready = !skid_v_ff;
   assign in_fire  = in_valid && !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || out_ready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= in_fire;
         end
      end else if (in_fire) begin
         // output held: park the incoming beat
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || out_ready) begin
         out_d_ff <= skid_v_ff ? skid_d_ff : in_data;
      end else if (in_fire) begin
         skid_d_ff <= in_data;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_d_ff;

endmodule
